@@ sv/assert_macros.svh @@
// assertion macros used by the player top file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_HOLDS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("assertion failed");

`endif

@@ sv/bsp_pkg.sv @@
// package: operation codes, status structs, field widths and default sizes of the byte player
package bsp_pkg;

    // default sizes
    localparam int BANK_COUNT_D     = 5;
    localparam int BANK_BYTES_D     = 64;
    localparam int DEBOUNCE_TICKS_D = 6;

    // fixed field widths
    localparam int OP_W     = 3;
    localparam int BYTE_W   = 8;
    localparam int STEPS_W  = 32;
    localparam int PERIOD_W = 16;

    // operation codes of an input transaction
    typedef enum logic [OP_W-1:0] {
        OP_TICK      = 3'd0,
        OP_WRITE     = 3'd1,
        OP_COMMIT    = 3'd2,
        OP_ABORT_SET = 3'd3,
        OP_ABORT_CLR = 3'd4,
        OP_ARM_SYNC  = 3'd5,
        OP_RESTART   = 3'd6
    } t_op;

    // index edge timing result for one tick
    typedef struct packed {
        logic                edge_qual;
        logic [PERIOD_W-1:0] period;
    } t_index_res;

    // result fields other than the port byte
    typedef struct packed {
        logic                step_valid;
        logic [STEPS_W-1:0]  step_count;
        logic [PERIOD_W-1:0] index_period;
        logic                abort_flag;
        logic                sync_armed;
        logic                all_empty;
        logic                write_ready;
    } t_status;

endpackage

@@ sv/bsp_if.sv @@
// channel interfaces of the byte player

interface bsp_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] op;
    logic [7:0] data_byte;
    logic       index_level;

    modport source (output valid, op, data_byte, index_level, input ready);
    modport sink (input valid, op, data_byte, index_level, output ready);
endinterface

interface bsp_out_if;
    logic        valid;
    logic        ready;
    logic        step_valid;
    logic [7:0]  port_byte;
    logic [31:0] step_count;
    logic [15:0] index_period;
    logic        abort_flag;
    logic        sync_armed;
    logic        all_empty;
    logic        write_ready;

    modport source (output valid, step_valid, port_byte, step_count, index_period,
                    abort_flag, sync_armed, all_empty, write_ready, input ready);
    modport sink (input valid, step_valid, port_byte, step_count, index_period,
                  abort_flag, sync_armed, all_empty, write_ready, output ready);
endinterface

@@ sv/bsp_bank_mem.sv @@
// byte store of all banks: one write port, one registered read port
module bsp_bank_mem
    import bsp_pkg::*;
#(
    parameter int DEPTH = BANK_COUNT_D * BANK_BYTES_D,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [AW-1:0]     i_wr_addr,
    input  logic [BYTE_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [AW-1:0]     i_rd_addr,
    output logic [BYTE_W-1:0] o_rd_data
);

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ sv/bsp_index.sv @@
// tick counter, index falling edge debounce and edge period latch
module bsp_index
    import bsp_pkg::*;
#(
    parameter int DEBOUNCE_TICKS = DEBOUNCE_TICKS_D
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_tick,
    input  logic       i_restart,
    input  logic       i_level,
    output t_index_res o_idx
);

    localparam int DW = $clog2(DEBOUNCE_TICKS + 1);
    localparam logic [DW-1:0] DEB_LIM = DW'(DEBOUNCE_TICKS);

    logic [PERIOD_W-1:0] r_tick_cnt, n_tick_cnt;
    logic [PERIOD_W-1:0] r_last_edge, n_last_edge;
    logic [PERIOD_W-1:0] r_period, n_period;
    logic [DW-1:0]       r_deb, n_deb;
    logic                r_prev, n_prev;
    logic [DW-1:0]       deb_inc;
    logic                edge_qual;

    assign deb_inc = r_deb + DW'(1);

    // next state of the edge timing
    always_comb begin
        n_tick_cnt  = r_tick_cnt;
        n_last_edge = r_last_edge;
        n_period    = r_period;
        n_deb       = r_deb;
        n_prev      = r_prev;
        edge_qual   = 1'b0;
        if (i_tick) begin
            n_tick_cnt = r_tick_cnt + PERIOD_W'(1);
            if (!i_level && r_prev) begin
                if (deb_inc >= DEB_LIM) begin
                    n_period    = n_tick_cnt - r_last_edge;
                    n_last_edge = n_tick_cnt;
                    n_deb       = '0;
                    n_prev      = 1'b0;
                    edge_qual   = 1'b1;
                end else begin
                    n_deb = deb_inc;
                end
            end else begin
                n_deb  = '0;
                n_prev = i_level;
            end
        end
        if (i_restart) begin
            n_last_edge = '0;
            n_period    = '0;
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_cnt  <= '0;
            r_last_edge <= '0;
            r_period    <= '0;
            r_deb       <= '0;
            r_prev      <= 1'b0;
        end else begin
            r_tick_cnt  <= n_tick_cnt;
            r_last_edge <= n_last_edge;
            r_period    <= n_period;
            r_deb       <= n_deb;
            r_prev      <= n_prev;
        end
    end

    assign o_idx.edge_qual = edge_qual;
    assign o_idx.period    = n_period;

endmodule

@@ sv/bsp_ring.sv @@
// bank ring control: fills, read offsets, bank pointers, flags and store addressing
module bsp_ring
    import bsp_pkg::*;
#(
    parameter int BANK_COUNT = BANK_COUNT_D,
    parameter int BANK_BYTES = BANK_BYTES_D,
    parameter int AW         = $clog2(BANK_COUNT * BANK_BYTES)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_acc,
    input  logic [OP_W-1:0]   i_op,
    input  logic [BYTE_W-1:0] i_data,
    input  t_index_res        i_idx,
    output logic              o_wr_en,
    output logic [AW-1:0]     o_wr_addr,
    output logic [BYTE_W-1:0] o_wr_data,
    output logic              o_rd_en,
    output logic [AW-1:0]     o_rd_addr,
    output t_status           o_stat
);

    localparam int BW = $clog2(BANK_COUNT);
    localparam int FW = $clog2(BANK_BYTES + 1);
    localparam int OW = $clog2(BANK_BYTES);
    localparam logic [FW-1:0] FILL_MAX = FW'(BANK_BYTES);
    localparam logic [BW-1:0] LAST_BANK = BW'(BANK_COUNT - 1);

    logic [FW-1:0]      r_fill [BANK_COUNT];
    logic [FW-1:0]      n_fill [BANK_COUNT];
    logic [OW-1:0]      r_roff [BANK_COUNT];
    logic [OW-1:0]      n_roff [BANK_COUNT];
    logic [FW-1:0]      r_wo, n_wo;
    logic [BW-1:0]      r_rb, n_rb;
    logic [BW-1:0]      r_wb, n_wb;
    logic               r_pend, n_pend;
    logic [STEPS_W-1:0] r_steps, n_steps;
    logic               r_abort, n_abort;
    logic               r_sync, n_sync;
    logic               drove, wr_go, empty_now, empty_next;
    logic [BW-1:0]      adv_bank;
    t_op                op;

    function automatic logic [BW-1:0] bank_after(input logic [BW-1:0] b);
        return (b == LAST_BANK) ? '0 : b + BW'(1);
    endfunction

    assign op = t_op'(i_op);

    // empty flags before and after this transaction
    always_comb begin
        empty_now  = 1'b1;
        empty_next = 1'b1;
        for (int i = 0; i < BANK_COUNT; i++) begin
            if (r_fill[i] != '0) empty_now = 1'b0;
            if (n_fill[i] != '0) empty_next = 1'b0;
        end
    end

    // next state of the ring for one transaction
    always_comb begin
        n_fill   = r_fill;
        n_roff   = r_roff;
        n_wo     = r_wo;
        n_rb     = r_rb;
        n_wb     = r_wb;
        n_pend   = r_pend;
        n_steps  = r_steps;
        n_abort  = r_abort;
        n_sync   = r_sync;
        drove    = 1'b0;
        wr_go    = 1'b0;
        adv_bank = '0;
        case (op)
            OP_TICK: begin
                if (!r_sync && r_fill[r_rb] != '0) begin
                    if (!r_abort) begin
                        drove   = 1'b1;
                        n_steps = r_steps + STEPS_W'(1);
                    end
                    n_roff[r_rb] = r_roff[r_rb] + OW'(1);
                    n_fill[r_rb] = r_fill[r_rb] - FW'(1);
                    if (r_fill[r_rb] == FW'(1)) begin
                        n_rb = bank_after(r_rb);
                    end
                end
                if (i_idx.edge_qual && r_sync && !empty_now) begin
                    n_sync = 1'b0;
                end
            end
            OP_WRITE: begin
                if (!r_pend && r_wo < FILL_MAX) begin
                    wr_go = 1'b1;
                    n_wo  = r_wo + FW'(1);
                end
            end
            OP_COMMIT: begin
                if (!r_pend) begin
                    n_fill[r_wb] = r_wo;
                    n_roff[r_wb] = '0;
                    n_pend       = 1'b1;
                end
            end
            OP_ABORT_SET: n_abort = 1'b1;
            OP_ABORT_CLR: n_abort = 1'b0;
            OP_ARM_SYNC:  n_sync  = 1'b1;
            OP_RESTART: begin
                for (int i = 0; i < BANK_COUNT; i++) begin
                    n_fill[i] = '0;
                    n_roff[i] = '0;
                end
                n_wo    = '0;
                n_rb    = '0;
                n_wb    = '0;
                n_pend  = 1'b0;
                n_steps = '0;
                n_abort = 1'b0;
                n_sync  = 1'b0;
            end
            default: ;
        endcase
        // advance the write bank when one is waiting and the next bank is not the read bank
        if (n_pend) begin
            adv_bank = bank_after(n_wb);
            if (adv_bank != n_rb) begin
                n_wb   = adv_bank;
                n_wo   = '0;
                n_pend = 1'b0;
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < BANK_COUNT; i++) begin
                r_fill[i] <= '0;
                r_roff[i] <= '0;
            end
            r_wo    <= '0;
            r_rb    <= '0;
            r_wb    <= '0;
            r_pend  <= 1'b0;
            r_steps <= '0;
            r_abort <= 1'b0;
            r_sync  <= 1'b0;
        end else if (i_acc) begin
            r_fill  <= n_fill;
            r_roff  <= n_roff;
            r_wo    <= n_wo;
            r_rb    <= n_rb;
            r_wb    <= n_wb;
            r_pend  <= n_pend;
            r_steps <= n_steps;
            r_abort <= n_abort;
            r_sync  <= n_sync;
        end
    end

    // store addressing
    assign o_wr_en   = i_acc && wr_go;
    assign o_wr_addr = AW'(r_wb) * AW'(BANK_BYTES) + AW'(r_wo);
    assign o_wr_data = i_data;
    assign o_rd_en   = i_acc && drove;
    assign o_rd_addr = AW'(r_rb) * AW'(BANK_BYTES) + AW'(r_roff[r_rb]);

    // result fields after this transaction
    assign o_stat.step_valid   = drove;
    assign o_stat.step_count   = n_steps;
    assign o_stat.index_period = i_idx.period;
    assign o_stat.abort_flag   = n_abort;
    assign o_stat.sync_armed   = n_sync;
    assign o_stat.all_empty    = empty_next;
    assign o_stat.write_ready  = !n_pend && (n_wo < FILL_MAX);

endmodule

@@ sv/step_byte_playout_with_index_period.sv @@
// Step/direction byte player. Takes one transaction per clock cycle, whatever the operation,
// unless the output stalls; each yields one result (control update and store access on
// acceptance, store read data and result register as its stage advances). The separate
// write and read ports of the byte store carry at most one byte write or one byte read per
// cycle, matching one operation per transaction. Ticks drive the next stored byte unless
// sync-start is armed or abort is set; a stalled output holds one result plus one in flight.
`include "assert_macros.svh"

module step_byte_playout_with_index_period
    import bsp_pkg::*;
#(
    parameter int BANK_COUNT     = BANK_COUNT_D,
    parameter int BANK_BYTES     = BANK_BYTES_D,
    parameter int DEBOUNCE_TICKS = DEBOUNCE_TICKS_D
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bsp_in_if.sink    i_in,
    bsp_out_if.source o_out
);

    localparam int DEPTH = BANK_COUNT * BANK_BYTES;
    localparam int AW    = $clog2(DEPTH);

    logic              acc, s1_adv, tick, restart;
    logic              wr_en, rd_en;
    logic [AW-1:0]     wr_addr, rd_addr;
    logic [BYTE_W-1:0] wr_data, rd_data, s1_port;
    t_index_res        idx;
    t_status           stat;

    logic              r_s1_valid;
    t_status           r_s1;
    logic              r_out_valid;
    t_status           r_out;
    logic [BYTE_W-1:0] r_out_port;
    logic [BYTE_W-1:0] r_port_latch;

    // transaction handshake
    assign s1_adv     = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_adv;
    assign acc        = i_in.valid && i_in.ready;
    assign tick       = acc && (i_in.op == OP_TICK);
    assign restart    = acc && (i_in.op == OP_RESTART);

    bsp_index #(
        .DEBOUNCE_TICKS (DEBOUNCE_TICKS)
    ) u_index (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tick    (tick),
        .i_restart (restart),
        .i_level   (i_in.index_level),
        .o_idx     (idx)
    );

    bsp_ring #(
        .BANK_COUNT (BANK_COUNT),
        .BANK_BYTES (BANK_BYTES),
        .AW         (AW)
    ) u_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_acc     (acc),
        .i_op      (i_in.op),
        .i_data    (i_in.data_byte),
        .i_idx     (idx),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .o_stat    (stat)
    );

    bsp_bank_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // port byte of the stage waiting on the store read
    assign s1_port = r_s1.step_valid ? rd_data : r_port_latch;

    // stage waiting on the store read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1 <= stat;
        end
    end

    // output register and last driven byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_port_latch <= '0;
        end else begin
            if (s1_adv) begin
                r_out_valid  <= 1'b1;
                r_port_latch <= s1_port;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out      <= r_s1;
            r_out_port <= s1_port;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.step_valid   = r_out.step_valid;
    assign o_out.port_byte    = r_out_port;
    assign o_out.step_count   = r_out.step_count;
    assign o_out.index_period = r_out.index_period;
    assign o_out.abort_flag   = r_out.abort_flag;
    assign o_out.sync_armed   = r_out.sync_armed;
    assign o_out.all_empty    = r_out.all_empty;
    assign o_out.write_ready  = r_out.write_ready;

    // checks
    `ASSERT_NEVER(a_no_take_when_full, i_clk, i_rst_n,
        r_s1_valid && r_out_valid && !o_out.ready && i_in.ready)
    `ASSERT_HOLDS(a_port_from_store, i_clk, i_rst_n,
        s1_adv && r_s1.step_valid |=> r_port_latch == $past(rd_data))
    `ASSERT_NEVER(a_step_flags, i_clk, i_rst_n,
        o_out.valid && o_out.step_valid && (o_out.abort_flag || o_out.sync_armed))

endmodule

@@ tb/sv/bsp_playout_checker.sv @@
// checker of the byte player: predicts each result from the accepted transactions and compares
module bsp_playout_checker
    import bsp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    bsp_in_if    i_in_mon,
    bsp_out_if   i_out_mon,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked,
    output int   o_played
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NBANK = BANK_COUNT_D;
    localparam int NBYTE = BANK_BYTES_D;
    localparam int NDEB  = DEBOUNCE_TICKS_D;

    typedef struct packed {
        t_status             st;
        logic [BYTE_W-1:0]   port_byte;
    } t_play_res;

    // predicted state of the player
    logic [7:0]          byte_mem [NBANK*NBYTE];
    logic [6:0]          bank_len [NBANK];
    logic [6:0]          bank_pos [NBANK];
    logic [6:0]          wr_pos;
    logic [2:0]          rd_bank;
    logic [2:0]          wr_bank;
    logic                adv_wait;
    logic [STEPS_W-1:0]  steps_q;
    logic [BYTE_W-1:0]   port_q;
    logic [PERIOD_W-1:0] tick_cnt;
    logic [PERIOD_W-1:0] edge_at;
    logic [PERIOD_W-1:0] period_q;
    logic [2:0]          low_run;
    logic                level_q;
    logic                abort_on;
    logic                sync_on;

    t_play_res play_q[$];
    t_play_res want;
    int        fail_cnt;
    int        checked_cnt;
    int        played_cnt;

    assign o_fail_count = fail_cnt;
    assign o_checked    = checked_cnt;
    assign o_played     = played_cnt;

    initial begin
        fail_cnt    = 0;
        checked_cnt = 0;
        played_cnt  = 0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        $display("mismatch on %s: got 0x%0h, expected 0x%0h (result %0d, t=%0t)",
                 what, got, exp_val, checked_cnt, $realtime);
        fail_cnt++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] exp_val);
        if (got !== exp_val) begin
            report_mismatch(what, got, exp_val);
        end
    endtask

    function automatic logic banks_drained();
        for (int b = 0; b < NBANK; b++) begin
            if (bank_len[b] != 0) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic logic [2:0] bank_after(input logic [2:0] b);
        return (int'(b) == NBANK - 1) ? 3'd0 : b + 3'd1;
    endfunction

    // the write bank moves on only if it would not land on the read bank
    function automatic void move_write_bank();
        logic [2:0] nb;
        nb = bank_after(wr_bank);
        if (nb != rd_bank) begin
            wr_bank  = nb;
            wr_pos   = '0;
            adv_wait = 1'b0;
        end else begin
            adv_wait = 1'b1;
        end
    endfunction

    function automatic void restart_playout();
        for (int b = 0; b < NBANK; b++) begin
            bank_len[b] = '0;
            bank_pos[b] = '0;
        end
        wr_pos   = '0;
        rd_bank  = '0;
        wr_bank  = '0;
        adv_wait = 1'b0;
        steps_q  = '0;
        edge_at  = '0;
        period_q = '0;
        abort_on = 1'b0;
        sync_on  = 1'b0;
    endfunction

    // apply one transaction to the predicted state and return the status after it
    function automatic t_play_res play_transaction(input logic [2:0] op, input logic [7:0] data,
                                                   input logic level);
        t_play_res r;
        logic      drove;
        drove = 1'b0;
        case (op)
            OP_TICK: begin
                // playout of one byte unless sync-start holds it back; under abort the byte is skipped
                if (!sync_on && bank_len[rd_bank] != 0) begin
                    if (!abort_on) begin
                        port_q = byte_mem[int'(rd_bank)*NBYTE + int'(bank_pos[rd_bank])];
                        steps_q++;
                        drove = 1'b1;
                    end
                    bank_pos[rd_bank]++;
                    bank_len[rd_bank]--;
                    if (bank_len[rd_bank] == 0) begin
                        rd_bank = bank_after(rd_bank);
                    end
                end
                // index edge debounce: low samples in a row after a high one
                tick_cnt++;
                if (level == 1'b0 && level_q == 1'b1) begin
                    low_run++;
                    if (int'(low_run) >= NDEB) begin
                        period_q = tick_cnt - edge_at;
                        edge_at  = tick_cnt;
                        low_run  = '0;
                        if (sync_on && !banks_drained()) begin
                            sync_on = 1'b0;
                        end
                        level_q = level;
                    end
                end else begin
                    low_run = '0;
                    level_q = level;
                end
            end
            OP_WRITE: begin
                if (!adv_wait && wr_pos < NBYTE) begin
                    byte_mem[int'(wr_bank)*NBYTE + int'(wr_pos)] = data;
                    wr_pos++;
                end
            end
            OP_COMMIT: begin
                if (!adv_wait) begin
                    bank_len[wr_bank] = wr_pos;
                    bank_pos[wr_bank] = '0;
                    move_write_bank();
                end
            end
            OP_ABORT_SET: abort_on = 1'b1;
            OP_ABORT_CLR: abort_on = 1'b0;
            OP_ARM_SYNC:  sync_on  = 1'b1;
            OP_RESTART:   restart_playout();
            default: ;
        endcase
        if (adv_wait) begin
            move_write_bank();
        end
        r.st.step_valid   = drove;
        r.st.step_count   = steps_q;
        r.st.index_period = period_q;
        r.st.abort_flag   = abort_on;
        r.st.sync_armed   = sync_on;
        r.st.all_empty    = banks_drained();
        r.st.write_ready  = !adv_wait && (wr_pos < NBYTE);
        r.port_byte       = port_q;
        return r;
    endfunction

    // monitor both channels
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            restart_playout();
            port_q   = '0;
            tick_cnt = '0;
            low_run  = '0;
            level_q  = 1'b0;
            play_q.delete();
        end else begin
            // returned result against the oldest prediction
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (play_q.size() == 0) begin
                    report_mismatch("result with no transaction waiting", 32'd0, 32'd0);
                end else begin
                    want = play_q.pop_front();
                    check_field("step_valid", i_out_mon.step_valid, want.st.step_valid);
                    check_field("port_byte", i_out_mon.port_byte, want.port_byte);
                    check_field("step_count", i_out_mon.step_count, want.st.step_count);
                    check_field("index_period", i_out_mon.index_period, want.st.index_period);
                    check_field("abort_flag", i_out_mon.abort_flag, want.st.abort_flag);
                    check_field("sync_armed", i_out_mon.sync_armed, want.st.sync_armed);
                    check_field("all_empty", i_out_mon.all_empty, want.st.all_empty);
                    check_field("write_ready", i_out_mon.write_ready, want.st.write_ready);
                    if (want.st.step_valid) begin
                        played_cnt++;
                    end
                    checked_cnt++;
                end
            end
            // accepted transaction
            if (i_in_mon.valid && i_in_mon.ready) begin
                play_q.push_back(play_transaction(i_in_mon.op, i_in_mon.data_byte,
                                                  i_in_mon.index_level));
            end
        end
        o_pending <= play_q.size();
    end

endmodule

@@ tb/sv/step_byte_playout_with_index_period_tb.sv @@
// top of the byte player testbench: clock, reset, stimulus, receiver stalls and verdict
module step_byte_playout_with_index_period_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bsp_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
    localparam int RAND_ITEMS = 1600;
    localparam int LONG_HOLD  = 300;
    localparam int RX_FLOW    = 0;
    localparam int RX_CHOPPY  = 1;
    localparam int RX_STALL   = 2;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bsp_in_if  in_ch ();
    bsp_out_if out_ch ();

    int fail_cnt;
    int pend_cnt;
    int checked_cnt;
    int played_cnt;

    // sender state
    int   sent_cnt = 0;
    int   op_seen [8];
    int   burst_left = 0;
    logic idx_level = 1'b0;
    int   idx_left = 0;
    logic hold_req = 1'b0;

    // receiver state
    logic hold_done = 1'b0;
    int   hold_left = 0;
    int   rx_mode = RX_FLOW;
    int   rx_left = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    step_byte_playout_with_index_period u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    bsp_playout_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .o_fail_count (fail_cnt),
        .o_pending    (pend_cnt),
        .o_checked    (checked_cnt),
        .o_played     (played_cnt)
    );

    // index input: high and low runs of random length, some lows long enough to qualify
    function automatic logic index_sample();
        if (idx_left == 0) begin
            idx_level = !idx_level;
            idx_left  = idx_level ? $urandom_range(1, 8) : $urandom_range(1, 10);
        end
        idx_left--;
        return idx_level;
    endfunction

    // offer one transaction in bursts with random gaps, wait until it is taken
    task automatic send_transaction(input logic [OP_W-1:0] op, input logic [7:0] data,
                                    input logic level);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 5);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                                      : $urandom_range(1, 20);
        end
        in_ch.valid       <= 1'b1;
        in_ch.op          <= op;
        in_ch.data_byte   <= data;
        in_ch.index_level <= level;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        burst_left--;
        sent_cnt++;
        op_seen[op]++;
    endtask

    task automatic play_ticks(input int n);
        repeat (n) send_transaction(OP_TICK, 8'($urandom), index_sample());
    endtask

    // a packet of n bytes followed by its commit
    task automatic load_packet(input int n);
        repeat (n) send_transaction(OP_WRITE, 8'($urandom), 1'($urandom));
        send_transaction(OP_COMMIT, 8'($urandom), 1'($urandom));
    endtask

    // hold the sender until every outstanding result has come back
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pend_cnt != 0) @(posedge i_clk);
        burst_left = 0;
    endtask

    // receiver: flowing, choppy and stalled stretches, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
            out_ch.ready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = $urandom_range(RX_FLOW, RX_STALL);
                rx_left = (rx_mode == RX_STALL) ? $urandom_range(1, 8) : $urandom_range(4, 60);
            end
            rx_left--;
            case (rx_mode)
                RX_FLOW:   out_ch.ready <= 1'b1;
                RX_CHOPPY: out_ch.ready <= ($urandom_range(0, 2) != 0);
                default:   out_ch.ready <= 1'b0;
            endcase
        end
    end

    // stimulus and verdict
    initial begin
        int sel;
        int len;
        logic drained;
        drained = 1'b0;
        foreach (op_seen[k]) op_seen[k] = 0;
        i_rst_n           <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.op          <= OP_TICK;
        in_ch.data_byte   <= '0;
        in_ch.index_level <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: unused code, empty packets up to a pending advance
        send_transaction(OP_RESTART, 8'h00, 1'b0);
        send_transaction(OP_UNUSED, 8'hFF, 1'b1);
        repeat (5) send_transaction(OP_COMMIT, 8'h00, 1'b0);
        send_transaction(OP_WRITE, 8'hA5, 1'b1);
        send_transaction(OP_COMMIT, 8'h5A, 1'b0);
        send_transaction(OP_TICK, 8'h00, 1'b1);
        send_transaction(OP_RESTART, 8'h00, 1'b0);
        // byte extremes, abort drop, sync-start released by a qualified index edge
        send_transaction(OP_WRITE, 8'h00, 1'b0);
        send_transaction(OP_WRITE, 8'hFF, 1'b1);
        send_transaction(OP_COMMIT, 8'h00, 1'b0);
        send_transaction(OP_ABORT_SET, 8'h00, 1'b0);
        send_transaction(OP_TICK, 8'h00, 1'b0);
        send_transaction(OP_ABORT_CLR, 8'h00, 1'b0);
        send_transaction(OP_ARM_SYNC, 8'h00, 1'b0);
        send_transaction(OP_TICK, 8'h00, 1'b1);
        repeat (DEBOUNCE_TICKS_D) send_transaction(OP_TICK, 8'h00, 1'b0);
        send_transaction(OP_TICK, 8'h00, 1'b0);
        drain_results();

        // random: mostly packets and tick runs, the rest control and noise
        while (sent_cnt < RAND_ITEMS) begin
            sel = $urandom_range(0, 99);
            if (sel < 40) begin
                len = $urandom_range(0, 9);
                if (len < 7) begin
                    len = $urandom_range(1, 16);
                end else if (len < 9) begin
                    len = $urandom_range(17, BANK_BYTES_D);
                end else begin
                    len = $urandom_range(BANK_BYTES_D - 4, BANK_BYTES_D + 6);
                end
                load_packet(len);
            end else if (sel < 80) begin
                play_ticks($urandom_range(1, 40));
            end else if (sel < 83) begin
                send_transaction(OP_ABORT_SET, 8'($urandom), 1'($urandom));
            end else if (sel < 89) begin
                send_transaction(OP_ABORT_CLR, 8'($urandom), 1'($urandom));
            end else if (sel < 93) begin
                send_transaction(OP_ARM_SYNC, 8'($urandom), 1'($urandom));
            end else if (sel < 95) begin
                send_transaction(OP_RESTART, 8'($urandom), 1'($urandom));
            end else if (sel < 96) begin
                send_transaction(OP_COMMIT, 8'($urandom), 1'($urandom));
            end else if (sel < 97) begin
                send_transaction(OP_UNUSED, 8'($urandom), 1'($urandom));
            end else begin
                send_transaction(3'($urandom_range(0, 7)), 8'($urandom), index_sample());
            end
            // long receiver hold-off while the sender keeps offering
            if (sent_cnt > 500) begin
                hold_req = 1'b1;
            end
            if (!drained && sent_cnt > 1000) begin
                drain_results();
                drained = 1'b1;
            end
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        $display("run covered %0d transactions: %0d ticks, %0d writes, %0d commits, %0d restarts",
                 sent_cnt, op_seen[OP_TICK], op_seen[OP_WRITE], op_seen[OP_COMMIT],
                 op_seen[OP_RESTART]);
        $display("%0d results compared, %0d bytes played to the step port",
                 checked_cnt, played_cnt);
        if (fail_cnt == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("timeout with %0d results outstanding", pend_cnt);
        $display("Some tests failed");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+sv
sv/bsp_pkg.sv
sv/bsp_if.sv
sv/bsp_bank_mem.sv
sv/bsp_index.sv
sv/bsp_ring.sv
sv/step_byte_playout_with_index_period.sv
tb/sv/bsp_playout_checker.sv
tb/sv/step_byte_playout_with_index_period_tb.sv
